[rtl/sida_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// sida_pkg
// Shared constants and types for the signed integer to decimal ASCII core.
// ---------------------------------------------------------------------------
package sida_pkg;

    // default width of the integer word
    localparam int DATA_WIDTH_DEF = 32;

    // width of one packed decimal digit
    localparam int BCD_W = 4;

    // ascii codes of the emitted characters
    localparam logic [7:0] ASCII_ZERO  = 8'd48;
    localparam logic [7:0] ASCII_MINUS = 8'd45;

    // control word shared by every digit cell of the chain
    typedef struct packed {
        logic clear;   // zero the digit
        logic shift;   // shift-add-3 step, one binary bit enters at the bottom
        logic move;    // move digits one place toward the top of the chain
    } cell_ctrl_t;

endpackage

`default_nettype wire

[rtl/signed_int_to_decimal_ascii_core.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// signed_int_to_decimal_ascii_core
// Converts a signed integer word into its decimal ASCII text, one character
// per output word, most significant first, last character flagged.
// ---------------------------------------------------------------------------
// One input word is taken at a time. After acceptance all DATA_WIDTH bits of
// the magnitude are shifted into a chain of decimal digit cells (double dabble,
// one bit per cycle). The digits are then moved out through the top cell:
// leading zeros are dropped without waiting on the output, each character
// goes out while the output is free, and a '-' is sent first for negative
// values. The output word register lets the next input be accepted while the
// last character of the previous number still waits.
module signed_int_to_decimal_ascii_core #(
    parameter int DATA_WIDTH = sida_pkg::DATA_WIDTH_DEF,
    localparam int IN_TDATA_W = ((DATA_WIDTH + 7) / 8) * 8
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   s_tvalid,
    output logic                  s_tready,
    input  wire [IN_TDATA_W-1:0]  s_tdata,    // [DATA_WIDTH-1:0] value, rest zero
    output logic                  m_tvalid,
    input  wire                   m_tready,
    output logic [7:0]            m_tdata,    // [7:0] out_char
    output logic                  m_tlast     // last_char
);

    // enough digits for the magnitude 2^(DATA_WIDTH-1)
    localparam int NUM_DIGITS = ((DATA_WIDTH - 1) * 1233) / 4096 + 1;
    localparam int BIT_CNT_W  = $clog2(DATA_WIDTH + 1);
    localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CONV = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t                   state_reg, state_next;
    logic [DATA_WIDTH-1:0]    mag_reg, mag_next;
    logic                     sign_reg, sign_next;
    logic                     started_reg, started_next;
    logic [BIT_CNT_W-1:0]     bit_cnt_reg, bit_cnt_next;
    logic [DIG_CNT_W-1:0]     dig_cnt_reg, dig_cnt_next;
    logic                     m_valid_reg, m_valid_next;
    logic [7:0]               m_char_reg, m_char_next;
    logic                     m_last_reg, m_last_next;

    logic [DATA_WIDTH-1:0]    in_raw;
    logic [DATA_WIDTH-1:0]    in_mag;
    logic                     out_free;
    sida_pkg::cell_ctrl_t     ctrl;
    logic [NUM_DIGITS-1:0]    bit_chain;
    logic [sida_pkg::BCD_W-1:0] digit_chain [NUM_DIGITS];
    logic [sida_pkg::BCD_W-1:0] top_digit;

    // magnitude of the incoming word, most negative value wraps to 2^(W-1)
    assign in_raw = s_tdata[DATA_WIDTH-1:0];
    assign in_mag = in_raw[DATA_WIDTH-1] ? (~in_raw + DATA_WIDTH'(1)) : in_raw;

    assign out_free  = !m_valid_reg || m_tready;
    assign top_digit = digit_chain[NUM_DIGITS-1];

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_char_reg;
    assign m_tlast  = m_last_reg;

    // digit cell chain, least significant digit at index zero
    for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
        sida_digit_cell u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .bit_in    ((i == 0) ? mag_reg[DATA_WIDTH-1] : bit_chain[(i == 0) ? 0 : i - 1]),
            .digit_in  ((i == 0) ? '0 : digit_chain[(i == 0) ? 0 : i - 1]),
            .bit_out   (bit_chain[i]),
            .digit_out (digit_chain[i])
        );
    end

    // sequencer: load, shift conversion, character output
    always_comb begin
        state_next   = state_reg;
        mag_next     = mag_reg;
        sign_next    = sign_reg;
        started_next = started_reg;
        bit_cnt_next = bit_cnt_reg;
        dig_cnt_next = dig_cnt_reg;
        m_valid_next = m_valid_reg;
        m_char_next  = m_char_reg;
        m_last_next  = m_last_reg;
        ctrl         = '0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    mag_next     = in_mag;
                    sign_next    = in_raw[DATA_WIDTH-1];
                    started_next = 1'b0;
                    bit_cnt_next = BIT_CNT_W'(DATA_WIDTH);
                    dig_cnt_next = DIG_CNT_W'(NUM_DIGITS);
                    ctrl.clear   = 1'b1;
                    state_next   = ST_CONV;
                end
            end
            ST_CONV: begin
                ctrl.shift   = 1'b1;
                mag_next     = {mag_reg[DATA_WIDTH-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg - BIT_CNT_W'(1);
                if (bit_cnt_reg == BIT_CNT_W'(1)) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (sign_reg) begin
                    // minus sign goes out first
                    if (out_free) begin
                        m_valid_next = 1'b1;
                        m_char_next  = sida_pkg::ASCII_MINUS;
                        m_last_next  = 1'b0;
                        sign_next    = 1'b0;
                    end
                end else if (!started_reg && top_digit == '0
                             && dig_cnt_reg > DIG_CNT_W'(1)) begin
                    // drop a leading zero
                    ctrl.move    = 1'b1;
                    dig_cnt_next = dig_cnt_reg - DIG_CNT_W'(1);
                end else if (out_free) begin
                    ctrl.move    = 1'b1;
                    started_next = 1'b1;
                    dig_cnt_next = dig_cnt_reg - DIG_CNT_W'(1);
                    m_valid_next = 1'b1;
                    m_char_next  = sida_pkg::ASCII_ZERO + {4'b0000, top_digit};
                    m_last_next  = (dig_cnt_reg == DIG_CNT_W'(1));
                    if (dig_cnt_reg == DIG_CNT_W'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            sign_reg    <= 1'b0;
            started_reg <= 1'b0;
            bit_cnt_reg <= '0;
            dig_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            sign_reg    <= sign_next;
            started_reg <= started_next;
            bit_cnt_reg <= bit_cnt_next;
            dig_cnt_reg <= dig_cnt_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        mag_reg    <= mag_next;
        m_char_reg <= m_char_next;
        m_last_reg <= m_last_next;
    end

endmodule

`default_nettype wire

[rtl/sida_digit_cell.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// sida_digit_cell
// One decimal digit of the conversion chain. During conversion it performs
// the add-3 correction and shifts one bit in from the lower neighbor; during
// output it takes the whole digit of the lower neighbor.
// ---------------------------------------------------------------------------
module sida_digit_cell (
    input  wire                          aclk,
    input  wire sida_pkg::cell_ctrl_t    ctrl,
    input  wire                          bit_in,
    input  wire [sida_pkg::BCD_W-1:0]    digit_in,
    output logic                         bit_out,
    output logic [sida_pkg::BCD_W-1:0]   digit_out
);

    logic [sida_pkg::BCD_W-1:0] digit_reg;
    logic [sida_pkg::BCD_W-1:0] digit_next;
    logic [sida_pkg::BCD_W-1:0] adjusted;

    // add-3 correction before the shift
    always_comb begin
        if (digit_reg >= sida_pkg::BCD_W'(5)) begin
            adjusted = digit_reg + sida_pkg::BCD_W'(3);
        end else begin
            adjusted = digit_reg;
        end
    end

    // carry toward the upper neighbor depends only on the stored digit
    assign bit_out   = adjusted[sida_pkg::BCD_W-1];
    assign digit_out = digit_reg;

    // next digit
    always_comb begin
        digit_next = digit_reg;
        if (ctrl.clear) begin
            digit_next = '0;
        end else if (ctrl.shift) begin
            digit_next = {adjusted[sida_pkg::BCD_W-2:0], bit_in};
        end else if (ctrl.move) begin
            digit_next = digit_in;
        end
    end

    always_ff @(posedge aclk) begin
        digit_reg <= digit_next;
    end

endmodule

`default_nettype wire

[rtl/sida_checker.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// sida_checker
// Port-level assertions for the signed integer to decimal ASCII core.
// ---------------------------------------------------------------------------
module sida_checker (
    input wire                   aclk,
    input wire                   aresetn,
    input wire                   s_tvalid,
    input wire                   s_tready,
    input wire                   m_tvalid,
    input wire                   m_tready,
    input wire [7:0]             m_tdata,
    input wire                   m_tlast
);

    // stalled output word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    // accepted word keeps the block busy on the next cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after accept");

    // a pending non-final character means a number is still in progress
    a_no_accept_mid_number: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input ready in the middle of a number");

    // only minus or digits appear
    a_char_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata == sida_pkg::ASCII_MINUS)
                     || (m_tdata >= sida_pkg::ASCII_ZERO && m_tdata <= 8'd57))
        else $error("illegal character code");

    // a sign never ends a number
    a_sign_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata == sida_pkg::ASCII_MINUS |-> !m_tlast)
        else $error("minus sign flagged as last");

endmodule

bind signed_int_to_decimal_ascii_core sida_checker u_sida_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

[verif/tb.sv]
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for signed_int_to_decimal_ascii_core: signed 32-bit
// words go in, their decimal text comes back one character per word. A short
// directed table covers zero, lone digits, edges around decimal powers and both
// extremes. A long random run follows, weighted toward digit-count
// boundaries. Random idle cycles are applied on both the input and output
// streams, with one stretch where neither side inserts idle cycles.
// ---------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW          = 32;
    localparam int RADIX       = 10;
    localparam int RANDOM_WORDS = 344;
    localparam int CALM_FIRST  = 140;
    localparam int CALM_LAST   = 220;
    localparam int DRAIN_WAIT  = 60;
    localparam int STALL_LIMIT = 3000;
    localparam int DIR_N       = 16;

    // directed table: value and its text, empty text means use the predictor
    localparam logic [DW-1:0] DIR_VALUE [DIR_N] = '{
        32'sd0, 32'sd1, -32'sd1, 32'sd9, 32'sd10, -32'sd10,
        32'h7fff_ffff, 32'h8000_0000, 32'h8000_0001,
        32'sd1000000000, 32'sd999999999, -32'sd1000000000,
        32'h5555_5555, 32'haaaa_aaaa, 32'sd12345, -32'sd987654321
    };
    string dir_text [DIR_N] = '{
        "0", "1", "-1", "9", "10", "-10",
        "2147483647", "-2147483648", "-2147483647",
        "1000000000", "999999999", "-1000000000",
        "", "", "", ""
    };

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } char_word_t;

    logic            aclk;
    logic            aresetn;
    logic            s_tvalid;
    logic            s_tready;
    logic [DW-1:0]   s_tdata;
    logic            m_tvalid;
    logic            m_tready;
    logic [7:0]      m_tdata;
    logic            m_tlast;

    char_word_t      expected_chars [$];
    bit              calm;
    int              err_count;
    int              chars_checked;
    int              words_sent;
    int              negatives_sent;
    int              stall_cycles;

    signed_int_to_decimal_ascii_core #(
        .DATA_WIDTH (DW)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // predictor: decimal text of a signed word, most significant first
    function automatic void predict_text(input logic [DW-1:0] value);
        logic [DW:0] mag;
        logic [7:0]  chars [$];
        mag = value[DW-1] ? ((DW+1)'(0) - {value[DW-1], value}) : {1'b0, value};
        do begin
            chars.push_front(sida_pkg::ASCII_ZERO + 8'(mag % RADIX));
            mag = mag / RADIX;
        end while (mag != 0);
        if (value[DW-1]) begin
            chars.push_front(sida_pkg::ASCII_MINUS);
        end
        for (int i = 0; i < chars.size(); i++) begin
            expected_chars.push_back('{chars[i], i == chars.size() - 1});
        end
    endfunction

    // expectation typed in as text
    function automatic void expect_text(input string text);
        for (int i = 0; i < text.len(); i++) begin
            expected_chars.push_back('{8'(text[i]), i == text.len() - 1});
        end
    endfunction

    function automatic longint unsigned pow10(input int k);
        longint unsigned p;
        p = 1;
        repeat (k) p = p * RADIX;
        return p;
    endfunction

    // random value, weighted toward digit-count edges and extremes
    function automatic logic [DW-1:0] pick_value();
        longint unsigned mag;
        logic [DW-1:0]   v;
        bit              neg;
        neg = $urandom_range(1);
        case ($urandom_range(9))
            3: begin
                v = DW'($urandom_range(198)) - DW'(99);
            end
            4: begin
                mag = pow10($urandom_range(9)) + $urandom_range(2) - 1;
                v = neg ? -DW'(mag) : DW'(mag);
            end
            5: begin
                case ($urandom_range(3))
                    0: v = 32'h7fff_ffff;
                    1: v = 32'h8000_0000;
                    2: v = 32'h8000_0001;
                    default: v = 32'h7fff_fffe;
                endcase
            end
            6, 7: begin
                mag = longint'($urandom) % pow10($urandom_range(10, 1));
                v = neg ? -DW'(mag) : DW'(mag);
            end
            default: begin
                v = $urandom;
            end
        endcase
        return v;
    endfunction

    // send one word, optional hold-off first; expectation queued on accept
    task automatic send_word(input logic [DW-1:0] value, input string text);
        int gap;
        gap = 0;
        if (!calm) begin
            if ($urandom_range(99) < 10) begin
                gap = $urandom_range(50, 1);
            end else begin
                while ($urandom_range(99) < 28) gap++;
            end
        end
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = value;
        do @(posedge aclk); while (!s_tready);
        if (text.len() != 0) begin
            expect_text(text);
        end else begin
            predict_text(value);
        end
        words_sent++;
        if (value[DW-1]) negatives_sent++;
        @(negedge aclk);
    endtask

    // output backpressure
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            m_tready = calm || ($urandom_range(99) >= 28);
        end
    end

    // compare each character word with the oldest expectation
    always @(posedge aclk) begin
        char_word_t exp_w;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_chars.size() == 0) begin
                $error("unexpected word: out_char %0d last_char %0b", m_tdata, m_tlast);
                err_count++;
            end else begin
                exp_w = expected_chars.pop_front();
                chars_checked++;
                if (m_tdata !== exp_w.ch) begin
                    $error("out_char: expected %0d, actual %0d", exp_w.ch, m_tdata);
                    err_count++;
                end
                if (m_tlast !== exp_w.last) begin
                    $error("last_char: expected %0b, actual %0b", exp_w.last, m_tlast);
                    err_count++;
                end
            end
        end
    end

    // watchdog: cycles with no word moving on either side
    initial begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
        end
        $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    // main sequence
    initial begin
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        calm           = 1'b0;
        err_count      = 0;
        chars_checked  = 0;
        words_sent     = 0;
        negatives_sent = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed table
        for (int i = 0; i < DIR_N; i++) begin
            send_word(DIR_VALUE[i], dir_text[i]);
        end

        // random words, one stretch with no idle cycles added on either side
        for (int i = 0; i < RANDOM_WORDS; i++) begin
            calm = (i >= CALM_FIRST) && (i < CALM_LAST);
            send_word(pick_value(), "");
        end
        calm     = 1'b0;
        s_tvalid = 1'b0;

        // drain, then watch for stray words
        while (expected_chars.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("%0d words sent (%0d negative), %0d characters checked",
                 words_sent, negatives_sent, chars_checked);
        if (err_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

[signed_int_to_decimal_ascii_core.f]
rtl/sida_pkg.sv
rtl/sida_digit_cell.sv
rtl/signed_int_to_decimal_ascii_core.sv
rtl/sida_checker.sv
verif/tb.sv
